// ===== rtl/cal_pkg.sv =====
// Shared types and constants for the cursor array list.
// No dependencies; every other file in rtl/ imports this package.
package cal_pkg;

    localparam int CAPACITY  = 64;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int KIND_W    = 4;

    // Value returned by a remove from an empty list (the character '0').
    localparam logic [WORD_BITS-1:0] EMPTY_READ = WORD_BITS'(48);

    typedef enum logic [KIND_W-1:0] {
        KIND_FIRST      = 4'd0,
        KIND_LAST       = 4'd1,
        KIND_NEXT       = 4'd2,
        KIND_PRIOR      = 4'd3,
        KIND_INS_AFTER  = 4'd4,
        KIND_INS_BEFORE = 4'd5,
        KIND_REMOVE     = 4'd6,
        KIND_REPLACE    = 4'd7,
        KIND_CLEAR      = 4'd8
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RM_CAP,
        ST_MOVE,
        ST_INS_WR,
        ST_RM_END,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0]           kind;
        logic signed [WORD_BITS-1:0] value;
    } req_t;

    typedef struct packed {
        logic                        ok;
        logic signed [WORD_BITS-1:0] read_value;
        logic [IDX_W-1:0]            cursor_pos;
        logic [CNT_W-1:0]            entry_count;
        logic                        is_empty;
        logic                        is_full;
    } res_t;

endpackage

// ===== rtl/cal_if.sv =====
// Valid/ready channel interfaces for the cursor array list requests and results.
// Depends on cal_pkg for field widths.
interface cal_req_if import cal_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [KIND_W-1:0]           kind;
    logic signed [WORD_BITS-1:0] value;

    modport source (output valid, kind, value, input ready);
    modport sink (input valid, kind, value, output ready);
endinterface

interface cal_rsp_if import cal_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic                        ok;
    logic signed [WORD_BITS-1:0] read_value;
    logic [IDX_W-1:0]            cursor_pos;
    logic [CNT_W-1:0]            entry_count;
    logic                        is_empty;
    logic                        is_full;

    modport source (output valid, ok, read_value, cursor_pos, entry_count, is_empty, is_full,
                    input ready);
    modport sink (input valid, ok, read_value, cursor_pos, entry_count, is_empty, is_full,
                  output ready);
endinterface

// ===== rtl/cal_core.sv =====
// List engine: entry memory, count, cursor and the sequencer that shifts entries.
// Depends on cal_pkg.
module cal_core import cal_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             idle,
    input  req_t             req,
    input  logic [CNT_W-1:0] limit,
    output logic             res_valid,
    input  logic             res_ready,
    output res_t             res
);

    logic [WORD_BITS-1:0] mem [CAPACITY];
    logic [WORD_BITS-1:0] rdata_reg;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     cur_reg, cur_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     left_reg, left_next;
    logic                 pend_reg, pend_next;
    logic                 ok_reg, ok_next;
    logic [WORD_BITS-1:0] rv_reg, rv_next;
    logic [WORD_BITS-1:0] value_reg, value_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic [IDX_W-1:0]     src_reg, src_next;
    logic [IDX_W-1:0]     pend_dst_reg, pend_dst_next;
    logic                 up_reg, up_next;

    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    logic [CNT_W-1:0]     eff_limit;
    logic                 empty;
    logic                 full;
    logic [CNT_W-1:0]     cur_ext;
    logic [IDX_W-1:0]     ins_pos;

    always_comb
    begin
        if (limit == '0)
        begin
            eff_limit = CNT_W'(1);
        end
        else if (limit > CNT_W'(CAPACITY))
        begin
            eff_limit = CNT_W'(CAPACITY);
        end
        else
        begin
            eff_limit = limit;
        end
    end

    assign empty   = (count_reg == '0);
    assign full    = (count_reg >= eff_limit);
    assign cur_ext = {{(CNT_W-IDX_W){1'b0}}, cur_reg};
    assign ins_pos = empty ? '0
                   : ((req.kind == KIND_INS_AFTER) ? cur_reg + IDX_W'(1) : cur_reg);

    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        count_next    = count_reg;
        left_next     = left_reg;
        pend_next     = 1'b0;
        ok_next       = ok_reg;
        rv_next       = rv_reg;
        value_next    = value_reg;
        pos_next      = pos_reg;
        src_next      = src_reg;
        pend_dst_next = pend_dst_reg;
        up_next       = up_reg;
        rd_en         = 1'b0;
        rd_addr       = cur_reg;
        wr_en         = 1'b0;
        wr_addr       = cur_reg;
        wr_data       = req.value;
        idle          = 1'b0;
        res_valid     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    ok_next    = 1'b0;
                    rv_next    = '0;
                    value_next = req.value;
                    state_next = ST_FINISH;
                    case (req.kind) inside
                        KIND_FIRST:
                        begin
                            if (!empty)
                            begin
                                cur_next = '0;
                                ok_next  = 1'b1;
                            end
                        end
                        KIND_LAST:
                        begin
                            if (!empty)
                            begin
                                cur_next = IDX_W'(count_reg - CNT_W'(1));
                                ok_next  = 1'b1;
                            end
                        end
                        KIND_NEXT:
                        begin
                            if (!empty && (cur_ext + CNT_W'(1) < count_reg))
                            begin
                                cur_next = cur_reg + IDX_W'(1);
                                ok_next  = 1'b1;
                            end
                        end
                        KIND_PRIOR:
                        begin
                            if (!empty && (cur_reg != '0))
                            begin
                                cur_next = cur_reg - IDX_W'(1);
                                ok_next  = 1'b1;
                            end
                        end
                        KIND_INS_AFTER, KIND_INS_BEFORE:
                        begin
                            if (!full)
                            begin
                                // Entries from the insert point to the end move up one place,
                                // highest first.
                                pos_next   = ins_pos;
                                src_next   = IDX_W'(count_reg - CNT_W'(1));
                                left_next  = count_reg - {{(CNT_W-IDX_W){1'b0}}, ins_pos};
                                up_next    = 1'b1;
                                state_next = ST_MOVE;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (empty)
                            begin
                                rv_next = EMPTY_READ;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = cur_reg;
                                state_next = ST_RM_CAP;
                            end
                        end
                        KIND_REPLACE:
                        begin
                            if (!empty)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = cur_reg;
                                wr_data = req.value;
                                ok_next = 1'b1;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            cur_next   = '0;
                            count_next = '0;
                            ok_next    = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_RM_CAP:
            begin
                // The removed word arrives here; entries after it move down one place.
                rv_next    = rdata_reg;
                src_next   = cur_reg + IDX_W'(1);
                left_next  = count_reg - CNT_W'(1) - cur_ext;
                up_next    = 1'b0;
                state_next = ST_MOVE;
            end

            ST_MOVE:
            begin
                // Read one entry per cycle and write the word read in the previous cycle.
                if (left_reg != '0)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = src_reg;
                    pend_next     = 1'b1;
                    pend_dst_next = up_reg ? src_reg + IDX_W'(1) : src_reg - IDX_W'(1);
                    src_next      = up_reg ? src_reg - IDX_W'(1) : src_reg + IDX_W'(1);
                    left_next     = left_reg - CNT_W'(1);
                end
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pend_dst_reg;
                    wr_data = rdata_reg;
                end
                if ((left_reg == '0) && !pend_reg)
                begin
                    state_next = up_reg ? ST_INS_WR : ST_RM_END;
                end
            end

            ST_INS_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = value_reg;
                cur_next   = pos_reg;
                count_next = count_reg + CNT_W'(1);
                ok_next    = 1'b1;
                state_next = ST_FINISH;
            end

            ST_RM_END:
            begin
                count_next = count_reg - CNT_W'(1);
                if (cur_ext >= count_reg - CNT_W'(1))
                begin
                    cur_next = '0;
                end
                ok_next    = 1'b1;
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.ok          = ok_reg;
    assign res.read_value  = rv_reg;
    assign res.cursor_pos  = cur_reg;
    assign res.entry_count = count_reg;
    assign res.is_empty    = empty;
    assign res.is_full     = full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cur_reg   <= '0;
            count_reg <= '0;
            left_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            count_reg <= count_next;
            left_reg  <= left_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg       <= ok_next;
        rv_reg       <= rv_next;
        value_reg    <= value_next;
        pos_reg      <= pos_next;
        src_reg      <= src_next;
        pend_dst_reg <= pend_dst_next;
        up_reg       <= up_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/cursor_array_list.sv =====
// Top level of the cursor array list: limit register, request intake and result register.
// Depends on cal_pkg, cal_if (cal_req_if, cal_rsp_if) and cal_core.
//
//   channel   direction  handshake          payload
//   req       in         valid/ready        kind, value
//   rsp       out        valid/ready        ok, read_value, cursor_pos, entry_count,
//                                           is_empty, is_full
//   cfg       in         cfg_we             cfg_wdata (capacity_limit)
//
// One word is worked on at a time. Insert and remove move the entries behind the insert
// or remove point one place, each with one read and one write on the single memory port
// pair; cursor moves, replace, clear and refused requests move no entries.
// Reset clears count, cursor and control state and sets the limit to 64; memory
// contents are not cleared. A result waiting on rsp does not block the next request.
module cursor_array_list import cal_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    cal_req_if.sink          req,
    cal_rsp_if.source        rsp,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata
);

    logic [CNT_W-1:0] limit_reg;
    logic             out_valid_reg;
    res_t             out_reg;

    logic             core_idle;
    logic             core_res_valid;
    logic             core_res_ready;
    res_t             core_res;
    req_t             core_req;

    assign core_req.kind  = req.kind;
    assign core_req.value = req.value;
    assign req.ready      = core_idle;

    // The result slot takes a new word when empty or when its word leaves this cycle.
    assign core_res_ready = !out_valid_reg || rsp.ready;

    cal_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (req.valid),
        .idle      (core_idle),
        .req       (core_req),
        .limit     (limit_reg),
        .res_valid (core_res_valid),
        .res_ready (core_res_ready),
        .res       (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= CNT_W'(CAPACITY);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (core_res_ready)
            begin
                out_valid_reg <= core_res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_res_ready && core_res_valid)
        begin
            out_reg <= core_res;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.ok          = out_reg.ok;
    assign rsp.read_value  = out_reg.read_value;
    assign rsp.cursor_pos  = out_reg.cursor_pos;
    assign rsp.entry_count = out_reg.entry_count;
    assign rsp.is_empty    = out_reg.is_empty;
    assign rsp.is_full     = out_reg.is_full;

endmodule
